### rtl/e2utc_pkg.sv
// ----------------------------------------------------------------------------
// e2utc_pkg: constants and tables for the epoch-to-UTC calendar converter
// Reciprocal multipliers for the constant divisions, the shifted day epoch,
// the 400-year era bounds and the month start table of the March-based year.
// ----------------------------------------------------------------------------
package e2utc_pkg;

  // Number of register stages from the accepted beat to the result strobe.
  localparam int unsigned LATENCY = 7;

  // Reciprocal for (seconds >> 7) / 675, i.e. seconds / 86400, exact below 2^25.
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam int unsigned DAY_RECIP_SH  = 35;
  localparam logic [9:0]  DAY_SECS_HI   = 10'd675;

  // Day count is shifted so that day zero is 0000-03-01.
  localparam logic [19:0] EPOCH_SHIFT   = 20'd719468;
  // Start of era 4 (year 1600) and era 5 (year 2000) in shifted days.
  localparam logic [19:0] ERA4_BASE     = 20'd584388;
  localparam logic [19:0] ERA5_BASE     = 20'd730485;

  // Day-of-era breakpoints where the century correction steps.
  localparam logic [17:0] CENT1_DAYS    = 18'd36524;
  localparam logic [17:0] CENT2_DAYS    = 18'd73048;
  localparam logic [17:0] CENT3_DAYS    = 18'd109572;
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;

  // Reciprocals for small constant divisions.
  localparam logic [16:0] W7_RECIP      = 17'd74899;   // x / 7,   x < 2^16
  localparam logic [16:0] Q1460_RECIP   = 17'd91930;   // x / 365, x < 2^16
  localparam logic [15:0] M60_RECIP     = 16'd34953;   // x / 15,  x < 2^15
  localparam logic [9:0]  H60_RECIP     = 10'd547;     // x / 15,  x < 2^9
  localparam logic [18:0] Y365_RECIP    = 19'd367720;  // x / 365, x < 2^18
  localparam logic [11:0] MP153_RECIP   = 12'd3427;    // x / 153, x < 2^11

  // March-based month index of January, and day offsets around the year turn.
  localparam logic [3:0]  MP_JANUARY    = 4'd10;
  localparam logic [8:0]  JAN1_DOY      = 9'd306;
  localparam logic [8:0]  MAR1_YDAY     = 9'd59;

  // First day of each March-based month, counted from March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    begin
      unique case (mp)
        4'd0:    start = 9'd0;
        4'd1:    start = 9'd31;
        4'd2:    start = 9'd61;
        4'd3:    start = 9'd92;
        4'd4:    start = 9'd122;
        4'd5:    start = 9'd153;
        4'd6:    start = 9'd184;
        4'd7:    start = 9'd214;
        4'd8:    start = 9'd245;
        4'd9:    start = 9'd275;
        4'd10:   start = 9'd306;
        4'd11:   start = 9'd337;
        default: start = 9'd0;
      endcase
      return start;
    end
  endfunction

endpackage

### rtl/epoch_seconds_to_utc_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar: Unix seconds to broken-down UTC time
// Seven-stage pipeline that splits a 32-bit second count into time of day,
// Gregorian date, weekday and day of year.
// ----------------------------------------------------------------------------
// A beat is taken on every clock edge where start_i is high and busy_o is low.
// busy_o is high only while the block comes out of reset and stays low from
// then on, so one timestamp can enter every cycle. Each result leaves in order,
// as a one-cycle valid_o strobe; the pipeline follows the chain of reciprocal
// multiplications (days, day of era, year of era, month), each of which takes
// its own stage. There is no back pressure on the result side: valid_o fires
// whether or not anyone listens.
module epoch_seconds_to_utc_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] epoch_seconds_i,
  output logic        busy_o,
  output logic        valid_o,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_index_o,
  output logic [7:0]  years_since_1900_o,
  output logic [2:0]  weekday_o,
  output logic [8:0]  day_of_year_o
);

  logic                                 accept;
  logic                                 busy_q;
  logic [e2utc_pkg::LATENCY-1:0]        valid_q;

  // Stage A: whole days.
  logic [50:0] a_prod;
  logic [15:0] days_a_d, days_a_q;
  logic [31:0] secs_a_q;

  // Stage B: seconds of day, day of era, weekday quotient.
  logic [24:0] b_days675;
  logic [9:0]  b_rem_hi;
  logic [19:0] b_shifted;
  logic        b_era5;
  logic [15:0] b_w;
  logic [32:0] b_wprod;
  logic [16:0] rem_b_d, rem_b_q;
  logic [17:0] doe_b_d, doe_b_q;
  logic        era5_b_q;
  logic [15:0] w_b_q;
  logic [12:0] q7_b_d, q7_b_q;

  // Stage C: corrected day of era, minutes of day, weekday.
  logic [32:0] c_prod;
  logic [7:0]  c_quad;
  logic [2:0]  c_cent;
  logic        c_last;
  logic [30:0] c_mprod;
  logic [15:0] c_wfull;
  logic [17:0] x_c_d, x_c_q;
  logic [17:0] doe_c_q;
  logic        era5_c_q;
  logic [16:0] rem_c_q;
  logic [10:0] mod_c_d, mod_c_q;
  logic [2:0]  wday_c_q;

  // Stage D: year of era, second, hour.
  logic [36:0] d_yprod;
  logic [16:0] d_sfull;
  logic [18:0] d_hprod;
  logic [8:0]  yoe_d_d, yoe_d_q;
  logic [17:0] doe_d_q;
  logic        era5_d_q;
  logic [10:0] mod_d_q;
  logic [4:0]  hour_d_d, hour_d_q;
  logic [5:0]  sec_d_d, sec_d_q;
  logic [2:0]  wday_d_q;

  // Stage E: day of March-based year, leap flag, minute.
  logic [1:0]  e_cent;
  logic [17:0] e_ydays;
  logic [17:0] e_doy_full;
  logic [10:0] e_mfull;
  logic [8:0]  doy_e_d, doy_e_q;
  logic [8:0]  yoe_e_q;
  logic        era5_e_q;
  logic        leap_e_d, leap_e_q;
  logic [4:0]  hour_e_q;
  logic [5:0]  sec_e_q;
  logic [5:0]  min_e_d, min_e_q;
  logic [2:0]  wday_e_q;

  // Stage F: March-based month.
  logic [10:0] f_mpin;
  logic [22:0] f_prod;
  logic [3:0]  mp_f_d, mp_f_q;
  logic [8:0]  doy_f_q;
  logic [8:0]  yoe_f_q;
  logic        era5_f_q;
  logic        leap_f_q;
  logic [4:0]  hour_f_q;
  logic [5:0]  sec_f_q;
  logic [5:0]  min_f_q;
  logic [2:0]  wday_f_q;

  // Stage G: output registers.
  logic        g_jan_feb;
  logic [8:0]  g_day_full;
  logic [10:0] g_year_full;
  logic [4:0]  day_g_d, day_g_q;
  logic [3:0]  month_g_d, month_g_q;
  logic [7:0]  year_g_d, year_g_q;
  logic [8:0]  yday_g_d, yday_g_q;
  logic [5:0]  sec_g_q;
  logic [5:0]  min_g_q;
  logic [4:0]  hour_g_q;
  logic [2:0]  wday_g_q;

  assign accept = start_i & ~busy_q;

  // Control: busy comes down in the cycle after reset, valid bits follow beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      valid_q <= '0;
    end else begin
      busy_q  <= 1'b0;
      valid_q <= {valid_q[e2utc_pkg::LATENCY-2:0], accept};
    end
  end

  // Stage A: days = seconds / 86400 through a reciprocal of 675 on seconds >> 7.
  always_comb begin
    a_prod   = 51'(epoch_seconds_i[31:7]) * 51'(e2utc_pkg::DAY_RECIP);
    days_a_d = a_prod[e2utc_pkg::DAY_RECIP_SH +: 16];
  end

  // Stage B: remainder of the day, era selection and weekday quotient.
  always_comb begin
    b_days675 = 25'(days_a_q) * 25'(e2utc_pkg::DAY_SECS_HI);
    b_rem_hi  = 10'(secs_a_q[31:7] - b_days675);
    rem_b_d   = {b_rem_hi, secs_a_q[6:0]};
    b_shifted = 20'(days_a_q) + e2utc_pkg::EPOCH_SHIFT;
    b_era5    = (b_shifted >= e2utc_pkg::ERA5_BASE);
    doe_b_d   = b_era5 ? 18'(b_shifted - e2utc_pkg::ERA5_BASE)
                       : 18'(b_shifted - e2utc_pkg::ERA4_BASE);
    // 1970-01-01 was a Thursday, so the weekday is (days + 4) mod 7.
    b_w       = days_a_q + 16'd4;
    b_wprod   = 33'(b_w) * 33'(e2utc_pkg::W7_RECIP);
    q7_b_d    = b_wprod[31:19];
  end

  // Stage C: leap-day corrections inside the era, minutes of day, weekday.
  always_comb begin
    c_prod  = 33'(doe_b_q[17:2]) * 33'(e2utc_pkg::Q1460_RECIP);
    c_quad  = c_prod[32:25];
    c_cent  = 3'(doe_b_q >= e2utc_pkg::CENT1_DAYS) + 3'(doe_b_q >= e2utc_pkg::CENT2_DAYS)
            + 3'(doe_b_q >= e2utc_pkg::CENT3_DAYS) + 3'(doe_b_q >= e2utc_pkg::ERA_LAST_DAY);
    c_last  = (doe_b_q == e2utc_pkg::ERA_LAST_DAY);
    x_c_d   = doe_b_q - 18'(c_quad) + 18'(c_cent) - 18'(c_last);
    c_mprod = 31'(rem_b_q[16:2]) * 31'(e2utc_pkg::M60_RECIP);
    mod_c_d = c_mprod[29:19];
    c_wfull = w_b_q - (16'(q7_b_q) * 16'd7);
  end

  // Stage D: year of era, second and hour.
  always_comb begin
    d_yprod  = 37'(x_c_q) * 37'(e2utc_pkg::Y365_RECIP);
    yoe_d_d  = d_yprod[35:27];
    d_sfull  = rem_c_q - (17'(mod_c_q) * 17'd60);
    sec_d_d  = d_sfull[5:0];
    d_hprod  = 19'(mod_c_q[10:2]) * 19'(e2utc_pkg::H60_RECIP);
    hour_d_d = d_hprod[17:13];
  end

  // Stage E: day of the March-based year, leap flag of that year, minute.
  always_comb begin
    e_cent     = 2'(yoe_d_q >= 9'd100) + 2'(yoe_d_q >= 9'd200) + 2'(yoe_d_q >= 9'd300);
    e_ydays    = 18'(yoe_d_q) * 18'd365 + 18'(yoe_d_q[8:2]) - 18'(e_cent);
    e_doy_full = doe_d_q - e_ydays;
    doy_e_d    = e_doy_full[8:0];
    // Eras start on a multiple of 400 years, so the year of era decides leap.
    leap_e_d   = (yoe_d_q[1:0] == 2'd0) && (yoe_d_q != 9'd100) &&
                 (yoe_d_q != 9'd200) && (yoe_d_q != 9'd300);
    e_mfull    = mod_d_q - (11'(hour_d_q) * 11'd60);
    min_e_d    = e_mfull[5:0];
  end

  // Stage F: March-based month = (5 * doy + 2) / 153.
  always_comb begin
    f_mpin = 11'(doy_e_q) * 11'd5 + 11'd2;
    f_prod = 23'(f_mpin) * 23'(e2utc_pkg::MP153_RECIP);
    mp_f_d = f_prod[22:19];
  end

  // Stage G: calendar fields; January and February belong to the next year.
  always_comb begin
    g_jan_feb   = (mp_f_q >= e2utc_pkg::MP_JANUARY);
    g_day_full  = doy_f_q - e2utc_pkg::month_start(mp_f_q) + 9'd1;
    day_g_d     = g_day_full[4:0];
    month_g_d   = g_jan_feb ? (mp_f_q - e2utc_pkg::MP_JANUARY) : (mp_f_q + 4'd2);
    g_year_full = 11'(yoe_f_q) + (era5_f_q ? 11'd400 : 11'd0) + 11'(g_jan_feb) - 11'd300;
    year_g_d    = g_year_full[7:0];
    yday_g_d    = g_jan_feb ? (doy_f_q - e2utc_pkg::JAN1_DOY)
                            : (doy_f_q + e2utc_pkg::MAR1_YDAY + 9'(leap_f_q));
  end

  // Payload registers of all stages; they move every cycle.
  always_ff @(posedge clk_i) begin
    days_a_q  <= days_a_d;
    secs_a_q  <= epoch_seconds_i;

    rem_b_q   <= rem_b_d;
    doe_b_q   <= doe_b_d;
    era5_b_q  <= b_era5;
    w_b_q     <= b_w;
    q7_b_q    <= q7_b_d;

    x_c_q     <= x_c_d;
    doe_c_q   <= doe_b_q;
    era5_c_q  <= era5_b_q;
    rem_c_q   <= rem_b_q;
    mod_c_q   <= mod_c_d;
    wday_c_q  <= c_wfull[2:0];

    yoe_d_q   <= yoe_d_d;
    doe_d_q   <= doe_c_q;
    era5_d_q  <= era5_c_q;
    mod_d_q   <= mod_c_q;
    hour_d_q  <= hour_d_d;
    sec_d_q   <= sec_d_d;
    wday_d_q  <= wday_c_q;

    doy_e_q   <= doy_e_d;
    yoe_e_q   <= yoe_d_q;
    era5_e_q  <= era5_d_q;
    leap_e_q  <= leap_e_d;
    hour_e_q  <= hour_d_q;
    sec_e_q   <= sec_d_q;
    min_e_q   <= min_e_d;
    wday_e_q  <= wday_d_q;

    mp_f_q    <= mp_f_d;
    doy_f_q   <= doy_e_q;
    yoe_f_q   <= yoe_e_q;
    era5_f_q  <= era5_e_q;
    leap_f_q  <= leap_e_q;
    hour_f_q  <= hour_e_q;
    sec_f_q   <= sec_e_q;
    min_f_q   <= min_e_q;
    wday_f_q  <= wday_e_q;

    day_g_q   <= day_g_d;
    month_g_q <= month_g_d;
    year_g_q  <= year_g_d;
    yday_g_q  <= yday_g_d;
    sec_g_q   <= sec_f_q;
    min_g_q   <= min_f_q;
    hour_g_q  <= hour_f_q;
    wday_g_q  <= wday_f_q;
  end

  // Outputs.
  assign busy_o             = busy_q;
  assign valid_o            = valid_q[e2utc_pkg::LATENCY-1];
  assign second_o           = sec_g_q;
  assign minute_o           = min_g_q;
  assign hour_o             = hour_g_q;
  assign day_of_month_o     = day_g_q;
  assign month_index_o      = month_g_q;
  assign years_since_1900_o = year_g_q;
  assign weekday_o          = wday_g_q;
  assign day_of_year_o      = yday_g_q;

`ifndef NO_ASSERTIONS
  // Every accepted beat produces its strobe once it has passed all pipeline stages.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 valid_o)
    else $error("accepted beat did not produce a result after seven cycles");

  // No strobe appears without a matching accepted beat.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 7))
    else $error("result strobe without a matching beat");

  // Time-of-day fields stay in range.
  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (second_o < 6'd60) && (minute_o < 6'd60) && (hour_o < 5'd24))
    else $error("time of day out of range");

  // Date fields stay in range.
  a_date_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (day_of_month_o != 5'd0) && (month_index_o < 4'd12) &&
                (weekday_o < 3'd7) && (day_of_year_o < 9'd366))
    else $error("calendar date out of range");

  // In January the day of year follows the day of month directly.
  a_january : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (month_index_o == 4'd0) |-> day_of_year_o == 9'(day_of_month_o) - 9'd1)
    else $error("January day of year disagrees with day of month");
`endif

endmodule
